### src/pcts_pkg.sv
package pcts_pkg;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_CONFIRM = 2'd1,
		KIND_SUBSCR  = 2'd2,
		KIND_ABORT   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		NOTE_NONE   = 2'd0,
		NOTE_HEADER = 2'd1,
		NOTE_DATA   = 2'd2,
		NOTE_DONE   = 2'd3
	} notice_t;

	localparam logic [1:0]  HANDLE_CTRL  = 2'd0;
	localparam logic [1:0]  HANDLE_AUDIO = 2'd1;
	localparam logic [15:0] MIN_CHUNK    = 16'd20;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;

	typedef struct packed {
		logic        subscribe_on;
		logic [1:0]  confirmed_handle;
		logic [15:0] sample_count;
		logic [15:0] chunk_request;
		logic [7:0]  conn_index;
		kind_t       kind;
	} item_t;

	typedef struct packed {
		logic        busy_res;
		logic        release_clip;
		logic [9:0]  byte_length;
		logic [14:0] byte_offset;
		logic [15:0] header_samples;
		logic [7:0]  conn_out;
		notice_t     notice;
	} result_t;

endpackage

### src/pcts_core.sv
module pcts_core #(
	parameter int MAX_CHUNK = 244
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  pcts_pkg::item_t   item,
	output pcts_pkg::result_t res
);

	localparam logic [15:0] MaxChunk = 16'(MAX_CHUNK);

	logic        active_q;
	logic        subscribed_q;
	logic [7:0]  conn_q;
	logic [9:0]  chunk_q;
	logic [15:0] total_q;
	logic [15:0] sent_q;

	logic [15:0] clamp_lo;
	logic [15:0] clamp;
	logic [16:0] samples_inc;
	logic [15:0] left;
	logic [15:0] chunk_ext;
	logic [15:0] take;
	logic        start_ok;
	logic        confirm_ok;
	logic        active_nx;

	always_comb begin
		clamp_lo    = (item.chunk_request < pcts_pkg::MIN_CHUNK) ? pcts_pkg::MIN_CHUNK
			: item.chunk_request;
		clamp       = (clamp_lo > MaxChunk) ? MaxChunk : clamp_lo;
		samples_inc = {1'b0, item.sample_count} + 17'd1;
		left        = total_q - sent_q;
		chunk_ext   = {6'd0, chunk_q};
		take        = (left > chunk_ext) ? chunk_ext : left;
		start_ok    = (item.kind == pcts_pkg::KIND_START) && !active_q && subscribed_q
			&& (item.sample_count != 16'd0);
		confirm_ok  = (item.kind == pcts_pkg::KIND_CONFIRM) && active_q
			&& ((item.confirmed_handle == pcts_pkg::HANDLE_CTRL)
			|| (item.confirmed_handle == pcts_pkg::HANDLE_AUDIO));
	end

	always_comb begin
		res       = '0;
		active_nx = active_q;
		res.notice = pcts_pkg::NOTE_NONE;
		if (start_ok) begin
			active_nx          = 1'b1;
			res.notice         = pcts_pkg::NOTE_HEADER;
			res.conn_out       = item.conn_index;
			res.header_samples = item.sample_count;
		end else if (confirm_ok) begin
			res.conn_out = conn_q;
			if (left == 16'd0) begin
				active_nx        = 1'b0;
				res.notice       = pcts_pkg::NOTE_DONE;
				res.release_clip = 1'b1;
			end else begin
				res.notice      = pcts_pkg::NOTE_DATA;
				res.byte_offset = sent_q[14:0];
				res.byte_length = take[9:0];
			end
		end else if (item.kind == pcts_pkg::KIND_ABORT) begin
			active_nx = 1'b0;
		end
		res.busy_res = active_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			subscribed_q <= 1'b0;
			conn_q       <= '0;
			chunk_q      <= '0;
			total_q      <= '0;
			sent_q       <= '0;
		end else if (fire) begin
			active_q <= active_nx;
			if (item.kind == pcts_pkg::KIND_SUBSCR) begin
				subscribed_q <= item.subscribe_on;
			end
			if (start_ok) begin
				conn_q  <= item.conn_index;
				chunk_q <= clamp[9:0];
				total_q <= samples_inc[16:1];
				sent_q  <= '0;
			end else if (confirm_ok && (left != 16'd0)) begin
				sent_q <= sent_q + take;
			end
		end
	end

endmodule

### src/paced_chunk_transfer_sequencer_unit.sv
// Channel  Dir  tuser         tdata
// s_axis   in   kind          conn_index, chunk_request, sample_count, handle, subscribe_on
// m_axis   out  notice        conn_out, header_samples, byte_offset, byte_length,
//                             release_clip, busy_res
//
// One transaction per cycle sustained while the output is not stalled; each item gives exactly one result.
// Each item passes through the input register, then the event logic and state update
// into the output register.
// Reset clears all transfer state, subscription and valid flags.
// A stalled output holds its result; the input register still drains into
// the output register whenever it is free or being taken.
module paced_chunk_transfer_sequencer_unit #(
	parameter int MAX_CHUNK = 244
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [7:0] conn_index, [23:8] chunk_request, [39:24] sample_count,
	// [41:40] confirmed_handle, [42] subscribe_on, [47:43] unused
	input  logic [pcts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] conn_out, [23:8] header_samples, [38:24] byte_offset,
	// [48:39] byte_length, [49] release_clip, [50] busy_res, [55:51] zero
	output logic [pcts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// [1:0] notice
	output logic [1:0]                        m_axis_tuser
);

	logic              valid_s1;
	pcts_pkg::item_t   item_s1;
	logic              out_valid_q;
	pcts_pkg::result_t out_q;
	pcts_pkg::result_t res;
	logic              advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind             <= pcts_pkg::kind_t'(s_axis_tuser);
			item_s1.conn_index       <= s_axis_tdata[7:0];
			item_s1.chunk_request    <= s_axis_tdata[23:8];
			item_s1.sample_count     <= s_axis_tdata[39:24];
			item_s1.confirmed_handle <= s_axis_tdata[41:40];
			item_s1.subscribe_on     <= s_axis_tdata[42];
		end
	end

	pcts_core #(
		.MAX_CHUNK(MAX_CHUNK)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.item  (item_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.notice;
	assign m_axis_tdata  = {5'd0, out_q.busy_res, out_q.release_clip, out_q.byte_length,
		out_q.byte_offset, out_q.header_samples, out_q.conn_out};

	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.notice == pcts_pkg::NOTE_DONE)
		|-> out_q.release_clip && !out_q.busy_res)
		else $error("done without release or still busy");

	a_header_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.notice == pcts_pkg::NOTE_HEADER) |-> out_q.busy_res)
		else $error("header without active transfer");

	a_chunk_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.notice == pcts_pkg::NOTE_DATA)
		|-> (out_q.byte_length != 10'd0) && (32'(out_q.byte_length) <= MAX_CHUNK))
		else $error("data chunk length out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without output backpressure");

endmodule
